// ===== sv/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants for the 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int CHAN_W        = 8;
    localparam int SUM_W         = CHAN_W + 1;
    localparam int NUM_CHAN      = 4;
    localparam int PIX_W         = NUM_CHAN * CHAN_W;
    localparam int LINE_W        = NUM_CHAN * SUM_W;
    localparam int DIM_W         = 12;
    localparam int ROW_W         = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_WIDTH_DEF = 2048;

    localparam logic [DIM_W-1:0] HEIGHT_CAP = 12'd2048;
    localparam logic [DIM_W-1:0] DIM_RESET  = 12'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // channel 0 = red ... channel 3 = alpha
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
    typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  sums_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_PAIR,
        MODE_QUAD
    } mode_t;

    // line store access for one accepted pixel
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        sums_t wr_data;
    } line_req_t;

    // work item handed to the averaging stage
    typedef struct packed {
        logic   emit;
        mode_t  mode;
        logic   eoi;
        pixel_t cur;
        pixel_t held;
    } item_t;

endpackage

// ===== sv/mbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbd_ctrl
// Configuration registers, raster position counters, held pixel and
// per-pixel decisions (emit, filter mode, end of image, line store access).
// ----------------------------------------------------------------------------
module mbd_ctrl #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
    parameter int AW        = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [mbd_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                          accept,
    input  mbd_pkg::pixel_t               pix,
    output mbd_pkg::line_req_t            line_req,
    output logic [AW-1:0]                 line_addr,
    output mbd_pkg::item_t                item
);

    localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int WW      = (mbd_pkg::DIM_W > MW_BITS) ? mbd_pkg::DIM_W : MW_BITS;
    localparam int CCW     = $clog2(MAX_WIDTH);

    logic [mbd_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [CCW-1:0]            col_reg, col_next;
    logic [mbd_pkg::ROW_W-1:0] row_reg, row_next;
    mbd_pkg::pixel_t           held_reg, held_next;

    logic [WW-1:0] w_eff, h_eff, c_ext, r_ext, wu, hu, p, len, used, c_inc, r_inc;
    logic [CCW-1:0] c_half;
    mbd_pkg::sums_t pair_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mbd_pkg::DIM_RESET;
            height_reg <= mbd_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mbd_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                mbd_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

    // effective dimensions: zero reads as one, large values saturate
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = WW'(1);
        end else if (height_reg > mbd_pkg::HEIGHT_CAP) begin
            h_eff = WW'(mbd_pkg::HEIGHT_CAP);
        end else begin
            h_eff = WW'(height_reg);
        end
    end

    assign c_ext  = WW'(col_reg);
    assign r_ext  = WW'(row_reg);
    assign wu     = w_eff & ~WW'(1);
    assign hu     = h_eff & ~WW'(1);
    assign p      = (w_eff == WW'(1)) ? r_ext : c_ext;
    assign len    = (w_eff == WW'(1)) ? h_eff : w_eff;
    assign used   = len & ~WW'(1);
    assign c_half = col_reg >> 1;
    assign c_inc  = c_ext + WW'(1);
    assign r_inc  = r_ext + WW'(1);

    always_comb begin
        for (int k = 0; k < mbd_pkg::NUM_CHAN; k++) begin
            pair_sum[k] = mbd_pkg::SUM_W'(held_reg[k]) + mbd_pkg::SUM_W'(pix[k]);
        end
    end

    always_comb begin
        held_next      = held_reg;
        item.emit      = 1'b0;
        item.mode      = mbd_pkg::MODE_PASS;
        item.eoi       = 1'b0;
        item.cur       = pix;
        item.held      = held_reg;
        line_req.wr_en = 1'b0;
        line_req.rd_en = 1'b0;
        line_req.wr_data = pair_sum;
        line_addr      = c_half[AW-1:0];

        if (w_eff == WW'(1) && h_eff == WW'(1)) begin
            item.emit = 1'b1;
            item.eoi  = 1'b1;
        end else if (w_eff == WW'(1) || h_eff == WW'(1)) begin
            if (p < used) begin
                if (!p[0]) begin
                    held_next = pix;
                end else begin
                    item.emit = 1'b1;
                    item.mode = mbd_pkg::MODE_PAIR;
                    item.eoi  = (p == used - WW'(1));
                end
            end
        end else if (c_ext < wu && r_ext < hu) begin
            if (!col_reg[0]) begin
                held_next = pix;
            end else if (!row_reg[0]) begin
                line_req.wr_en = accept;
            end else begin
                line_req.rd_en = accept;
                item.emit = 1'b1;
                item.mode = mbd_pkg::MODE_QUAD;
                item.eoi  = (r_ext == hu - WW'(1)) && (c_ext == wu - WW'(1));
            end
        end
    end

    // raster advance; wraps at the end of the image
    always_comb begin
        if (c_inc >= w_eff) begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[mbd_pkg::ROW_W-1:0];
        end else begin
            col_next = c_inc[CCW-1:0];
            row_next = row_reg;
        end
    end

endmodule

// ===== sv/mbd_line_buf.sv =====
// ----------------------------------------------------------------------------
// mbd_line_buf
// Single-port line store of even-row pair sums, registered read data.
// ----------------------------------------------------------------------------
module mbd_line_buf #(
    parameter int DEPTH = mbd_pkg::MAX_WIDTH_DEF / 2,
    parameter int AW    = 10
) (
    input  logic               aclk,
    input  mbd_pkg::line_req_t req,
    input  logic [AW-1:0]      addr,
    output mbd_pkg::sums_t     rd_data
);

    mbd_pkg::sums_t line_mem [DEPTH];
    mbd_pkg::sums_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            line_mem[addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= line_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mbd_avg.sv =====
// ----------------------------------------------------------------------------
// mbd_avg
// Item register, channel averaging and output register with handshake.
// ----------------------------------------------------------------------------
module mbd_avg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  mbd_pkg::item_t         item,
    input  mbd_pkg::sums_t         line_sum,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mbd_pkg::pixel_t        out_pix,
    output logic                   out_last
);

    logic            s1_valid_reg;
    mbd_pkg::item_t  s1_item_reg;
    logic            out_valid_reg;
    mbd_pkg::pixel_t out_pix_reg, out_pix_next;
    logic            out_last_reg;
    logic            s1_move;

    logic [mbd_pkg::SUM_W:0] quad_sum [mbd_pkg::NUM_CHAN];
    logic [mbd_pkg::SUM_W-1:0] pair_sum [mbd_pkg::NUM_CHAN];

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    always_comb begin
        for (int k = 0; k < mbd_pkg::NUM_CHAN; k++) begin
            pair_sum[k] = mbd_pkg::SUM_W'(s1_item_reg.held[k])
                        + mbd_pkg::SUM_W'(s1_item_reg.cur[k]);
            quad_sum[k] = (mbd_pkg::SUM_W + 1)'(line_sum[k])
                        + (mbd_pkg::SUM_W + 1)'(pair_sum[k]);
            case (s1_item_reg.mode)
                mbd_pkg::MODE_PAIR: out_pix_next[k] = pair_sum[k][mbd_pkg::SUM_W-1:1];
                mbd_pkg::MODE_QUAD: out_pix_next[k] = quad_sum[k][mbd_pkg::SUM_W:2];
                default:            out_pix_next[k] = s1_item_reg.cur[k];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_item_reg <= item;
        end
        if (s1_move) begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= s1_item_reg.eoi;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/mipmap_box_downsample_top.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_downsample_top
// One mip level of an RGBA8 texture by a 2x2 box filter, streaming.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock in raster order, while s_tready is high, and
// produces the next mip level in raster order; a result passes from the
// item register to the output register, and input stays open while a result
// waits, as long as the one-item stage behind the input is free. 2D images
// average each aligned 2x2 block (sum >> 2) using a MAX_WIDTH/2 x 36-bit
// single-port line store of even-row pair sums; the store is not cleared and
// needs no init pass. Width or height of 1 averages pixel pairs (sum >> 1),
// 1x1 passes the pixel through. A trailing odd column or row is dropped.
// m_tlast marks the final pixel of each mip level. Write image_width (index 0)
// and image_height (index 1) only between images.
module mipmap_box_downsample_top #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [mbd_pkg::DIM_W-1:0]     cfg_wdata,
    // input pixels
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mbd_pkg::PIX_W-1:0]     s_tdata,   // in_red, in_green, in_blue, in_alpha
    // mip pixels
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbd_pkg::PIX_W-1:0]     m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                          m_tlast    // end_of_image
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic               accept;
    mbd_pkg::pixel_t    in_pix, out_pix;
    mbd_pkg::line_req_t line_req;
    logic [AW-1:0]      line_addr;
    mbd_pkg::sums_t     line_sum;
    mbd_pkg::item_t     item;

    assign accept = s_tvalid && s_tready;
    assign in_pix = mbd_pkg::pixel_t'(s_tdata);

    mbd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .pix       (in_pix),
        .line_req  (line_req),
        .line_addr (line_addr),
        .item      (item)
    );

    mbd_line_buf #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_buf (
        .aclk    (aclk),
        .req     (line_req),
        .addr    (line_addr),
        .rd_data (line_sum)
    );

    mbd_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && item.emit),
        .item      (item),
        .line_sum  (line_sum),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix),
        .out_last  (m_tlast)
    );

    assign m_tdata = mbd_pkg::PIX_W'(out_pix);

endmodule

// ===== sim/tb_mipmap_box_downsample_top.sv =====
// ----------------------------------------------------------------------------
// tb_mipmap_box_downsample_top
// Self-checking bench for the streaming 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
// Whole images of RGBA8 pixels are queued together with the size writes
// that precede them. A clocked driver plays the queue onto the input stream
// with random gaps, and the output stream sees random back-pressure. A
// monitor predicts every mip pixel when its completing input transaction
// is accepted, then checks each output transaction channel by channel,
// including the end-of-image flag.
module tb_mipmap_box_downsample_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RAND_PIXELS   = 630;
    localparam int CALM_PIXELS   = 150;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    typedef enum logic [1:0] {
        ACT_PIXEL,
        ACT_CONFIG,
        ACT_DRAIN
    } act_kind_t;

    typedef struct {
        act_kind_t                           kind;
        mbd_pkg::pixel_t                     px;
        logic [mbd_pkg::CFG_IDX_W-1:0]       reg_idx;
        logic [mbd_pkg::DIM_W-1:0]           reg_val;
        bit                                  gappy;
    } stim_t;

    typedef struct {
        mbd_pkg::pixel_t rgba;
        logic            eoi;
    } mip_px_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [mbd_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [mbd_pkg::DIM_W-1:0]     cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [mbd_pkg::PIX_W-1:0]     s_tdata;   // in_red, in_green, in_blue, in_alpha
    logic                          m_tvalid;
    logic                          m_tready;
    logic [mbd_pkg::PIX_W-1:0]     m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic                          m_tlast;   // end_of_image

    mipmap_box_downsample_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    stim_t   stim_q[$];
    mip_px_t mip_expect[$];

    // predictor state
    logic [mbd_pkg::DIM_W-1:0] cfg_width  = mbd_pkg::DIM_RESET;
    logic [mbd_pkg::DIM_W-1:0] cfg_height = mbd_pkg::DIM_RESET;
    int unsigned               col_pos    = 0;
    int unsigned               row_pos    = 0;
    mbd_pkg::pixel_t           held_px    = '0;
    mbd_pkg::sums_t            line_sums [mbd_pkg::MAX_WIDTH_DEF/2];

    int errors       = 0;
    int pixels_in    = 0;
    int mips_checked = 0;
    int cfg_writes   = 0;
    int images       = 0;

    int gap_left     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    bit gappy_now    = 1'b0;

    function automatic int unsigned eff_dim(input logic [mbd_pkg::DIM_W-1:0] v,
                                            input logic [mbd_pkg::DIM_W-1:0] cap);
        if (v == '0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    function automatic mbd_pkg::pixel_t rand_pixel();
        mbd_pkg::pixel_t px;
        for (int k = 0; k < mbd_pkg::NUM_CHAN; k++) begin
            case ($urandom_range(0, 7))
                0: px[k] = 8'h00;
                1: px[k] = 8'hFF;
                default: px[k] = 8'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // next mip pixel, if this input pixel completes one
    task automatic mip_predict(input mbd_pkg::pixel_t px);
        int unsigned w, h, c, r, p, len, used, wu, hu, slot;
        mip_px_t res;
        bit emit;
        w = eff_dim(cfg_width, mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH_DEF));
        h = eff_dim(cfg_height, mbd_pkg::HEIGHT_CAP);
        c = col_pos;
        r = row_pos;
        emit = 1'b0;
        if (w == 1 && h == 1) begin
            res.rgba = px;
            res.eoi  = 1'b1;
            emit     = 1'b1;
        end else if (w == 1 || h == 1) begin
            // a single line or column: average consecutive pairs
            p    = (w == 1) ? r : c;
            len  = (w == 1) ? h : w;
            used = len & ~32'd1;
            if (p < used) begin
                if (!p[0]) begin
                    held_px = px;
                end else begin
                    for (int k = 0; k < mbd_pkg::NUM_CHAN; k++)
                        res.rgba[k] = 8'((int'(held_px[k]) + int'(px[k])) >> 1);
                    res.eoi = (p == used - 1);
                    emit    = 1'b1;
                end
            end
        end else begin
            wu = w & ~32'd1;
            hu = h & ~32'd1;
            if (c < wu && r < hu) begin
                slot = c >> 1;
                if (!c[0]) begin
                    held_px = px;
                end else if (!r[0]) begin
                    for (int k = 0; k < mbd_pkg::NUM_CHAN; k++)
                        line_sums[slot][k] = 9'(int'(held_px[k]) + int'(px[k]));
                end else begin
                    for (int k = 0; k < mbd_pkg::NUM_CHAN; k++)
                        res.rgba[k] = 8'((int'(line_sums[slot][k]) + int'(held_px[k])
                                          + int'(px[k])) >> 2);
                    res.eoi = (r == hu - 1) && (c == wu - 1);
                    emit    = 1'b1;
                end
            end
        end
        if (emit)
            mip_expect.push_back(res);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // size writes, then every pixel of one image; optional drain at mid-image
    task automatic queue_image(input logic [mbd_pkg::DIM_W-1:0] w_raw,
                               input logic [mbd_pkg::DIM_W-1:0] h_raw,
                               input bit gappy, input int fill, input bit pause_mid);
        stim_t it;
        int unsigned n;
        it.px      = '0;
        it.gappy   = gappy;
        it.kind    = ACT_CONFIG;
        it.reg_idx = mbd_pkg::CFG_IMAGE_WIDTH;
        it.reg_val = w_raw;
        stim_q.push_back(it);
        it.reg_idx = mbd_pkg::CFG_IMAGE_HEIGHT;
        it.reg_val = h_raw;
        stim_q.push_back(it);
        n = eff_dim(w_raw, mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH_DEF))
          * eff_dim(h_raw, mbd_pkg::HEIGHT_CAP);
        for (int unsigned i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) begin
                it.kind = ACT_DRAIN;
                stim_q.push_back(it);
            end
            it.kind = ACT_PIXEL;
            case (fill)
                FILL_ONES:  it.px = '1;
                FILL_ZEROS: it.px = '0;
                default:    it.px = rand_pixel();
            endcase
            stim_q.push_back(it);
        end
        images++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // input side
    always @(posedge aclk) begin : drive_proc
        logic send_px;
        logic do_write;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            cfg_wr_en <= 1'b0;
            cfg_addr  <= '0;
            cfg_wdata <= '0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            if (mip_expect.size() == 0 && !s_tvalid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!(s_tvalid && !s_tready)) begin
                send_px  = 1'b0;
                do_write = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() != 0) begin
                    case (stim_q[0].kind)
                        ACT_PIXEL: begin
                            s_tdata <= stim_q[0].px;
                            send_px   = 1'b1;
                            gappy_now = stim_q[0].gappy;
                            if (gappy_now && $urandom_range(0, 4) == 0)
                                gap_left = $urandom_range(1, 4);
                            void'(stim_q.pop_front());
                        end
                        ACT_CONFIG: begin
                            // block must be idle, also after pixels that made no result
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                cfg_addr  <= stim_q[0].reg_idx;
                                cfg_wdata <= stim_q[0].reg_val;
                                do_write = 1'b1;
                                cfg_writes++;
                                void'(stim_q.pop_front());
                            end
                        end
                        default: begin
                            // wait until no pixel is pending on the input and every predicted result is checked
                            if (!s_tvalid && mip_expect.size() == 0)
                                void'(stim_q.pop_front());
                        end
                    endcase
                end
                s_tvalid  <= send_px;
                cfg_wr_en <= do_write;
            end
        end
    end

    // output back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else if (gappy_now && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check results, track register writes, predict on accepted pixels
    always @(posedge aclk) begin : monitor_proc
        mip_px_t         want;
        mbd_pkg::pixel_t got;
        string           chan_name [mbd_pkg::NUM_CHAN];
        chan_name = '{"red", "green", "blue", "alpha"};
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (mip_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected mip pixel %h last=%b",
                                              m_tdata, m_tlast));
                end else begin
                    want = mip_expect.pop_front();
                    for (int k = 0; k < mbd_pkg::NUM_CHAN; k++)
                        if (got[k] !== want.rgba[k])
                            report_mismatch($sformatf("mip pixel %0d %s: got %h want %h",
                                                      mips_checked, chan_name[k],
                                                      got[k], want.rgba[k]));
                    if (m_tlast !== want.eoi)
                        report_mismatch($sformatf("mip pixel %0d end_of_image: got %b want %b",
                                                  mips_checked, m_tlast, want.eoi));
                    mips_checked++;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    mbd_pkg::CFG_IMAGE_WIDTH:  cfg_width  = cfg_wdata;
                    mbd_pkg::CFG_IMAGE_HEIGHT: cfg_height = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                mip_predict(s_tdata);
                pixels_in++;
            end
        end
    end

    initial begin
        logic [mbd_pkg::DIM_W-1:0] w, h;
        int  rand_pixels;
        bit  gappy;
        aresetn = 1'b0;

        // directed: zero sizes act as 1x1 pass-through, max sums,
        // dropped odd column and row, single column and single row
        queue_image(12'd0, 12'd0, 1'b0, FILL_ONES, 1'b0);
        queue_image(12'd1, 12'd1, 1'b0, FILL_ZEROS, 1'b0);
        queue_image(12'd2, 12'd2, 1'b1, FILL_ONES, 1'b0);
        queue_image(12'd3, 12'd3, 1'b1, FILL_RANDOM, 1'b0);
        queue_image(12'd1, 12'd3, 1'b1, FILL_ONES, 1'b0);
        queue_image(12'd3, 12'd1, 1'b1, FILL_RANDOM, 1'b0);

        // a wide 2D image with a full drain halfway, and a tall single column
        queue_image(12'd200, 12'd2, 1'b1, FILL_RANDOM, 1'b1);
        queue_image(12'd1, 12'd100, 1'b1, FILL_RANDOM, 1'b0);

        rand_pixels = 0;
        while (rand_pixels < RAND_PIXELS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    w = 12'd1;
                    h = mbd_pkg::DIM_W'($urandom_range(1, 24));
                end
                2, 3: begin
                    w = mbd_pkg::DIM_W'($urandom_range(1, 24));
                    h = 12'd1;
                end
                4: begin
                    w = mbd_pkg::DIM_W'($urandom_range(0, 1) ? 0 : $urandom_range(2, 12));
                    h = mbd_pkg::DIM_W'($urandom_range(0, 1) ? 0 : $urandom_range(2, 12));
                end
                5: begin
                    w = mbd_pkg::DIM_W'($urandom_range(17, 64));
                    h = mbd_pkg::DIM_W'($urandom_range(2, 4));
                end
                default: begin
                    w = mbd_pkg::DIM_W'($urandom_range(2, 16));
                    h = mbd_pkg::DIM_W'($urandom_range(2, 8));
                end
            endcase
            gappy = (rand_pixels < RAND_PIXELS - CALM_PIXELS) && ($urandom_range(0, 4) != 0);
            queue_image(w, h, gappy, FILL_RANDOM, $urandom_range(0, 7) == 0);
            rand_pixels += eff_dim(w, mbd_pkg::DIM_W'(mbd_pkg::MAX_WIDTH_DEF))
                         * eff_dim(h, mbd_pkg::HEIGHT_CAP);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || mip_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mip_expect.size() != 0)
            report_mismatch($sformatf("%0d mip pixels never arrived", mip_expect.size()));

        $display("covered %0d images (1x1, zero sizes, single rows and columns, 2D), %0d register writes",
                 images, cfg_writes);
        $display("%0d pixels in, %0d mip pixels checked, %0d mismatches",
                 pixels_in, mips_checked, errors);
        if (errors == 0) begin
            $display("tb_mipmap_box_downsample_top: PASS");
        end else begin
            $display("tb_mipmap_box_downsample_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("tb_mipmap_box_downsample_top: FAIL");
        $finish;
    end

endmodule

// ===== mipmap_box_downsample_top.f =====
sv/mbd_pkg.sv
sv/mbd_ctrl.sv
sv/mbd_line_buf.sv
sv/mbd_avg.sv
sv/mipmap_box_downsample_top.sv
sim/tb_mipmap_box_downsample_top.sv
